FILE: hw/rtl/wep_pkg.sv
// wep_pkg: shared types, constants and the saturation helper of the edge projector
// used by the sine, lane, merge and top modules of the block, depends on nothing

package wep_pkg;

    typedef enum logic [2:0] {
        CFG_SPEED_X  = 3'd0,
        CFG_SPEED_Y  = 3'd1,
        CFG_VIEW     = 3'd2,
        CFG_ZOOM     = 3'd3,
        CFG_CENTER_X = 3'd4,
        CFG_CENTER_Y = 3'd5
    } t_cfg_idx;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_EDGE = 1'b1;

    localparam logic [30:0] POLY_C1 = 31'd1686629713;
    localparam logic [30:0] POLY_C3 = 31'd693598669;
    localparam logic [30:0] POLY_C5 = 31'd85569306;
    localparam logic [30:0] POLY_C7 = 31'd5026997;
    localparam logic [30:0] POLY_C9 = 31'd172272;

    localparam logic signed [20:0] MIN_Z = 21'sd819;

    typedef struct packed {
        logic signed [15:0] snx;
        logic signed [15:0] csx;
        logic signed [15:0] sny;
        logic signed [15:0] csy;
    } t_trig;

    typedef struct packed {
        logic [15:0] view_distance;
        logic [15:0] zoom;
        logic [11:0] center_x;
        logic [11:0] center_y;
    } t_view;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } t_point;

    function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
        logic signed [15:0] r;
        if (v > 37'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -37'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/wep_div.sv
// wep_div: restoring serial divider, one quotient bit per cycle
// depends on nothing

module wep_div #(
    parameter int NW = 35,
    parameter int DW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem, r_den;
    logic [DW:0]   w_sh, w_sub;
    logic          w_bit;

    assign w_sh  = {r_rem, r_num[NW-1]};
    assign w_sub = w_sh - {1'b0, r_den};
    assign w_bit = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], w_bit};
            r_rem <= w_bit ? w_sub[DW-1:0] : w_sh[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: hw/rtl/wep_sine.sv
// wep_sine: sine of a quantised phase, odd degree 9 polynomial on one shared multiplier
// depends on wep_pkg

module wep_sine import wep_pkg::*; #(
    parameter int ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_phase,
    input  logic               i_cos,
    output logic               o_done,
    output logic signed [15:0] o_value
);
    localparam int IW = $clog2(ENTRIES);
    localparam int NW = $clog2(ENTRIES + 1);
    localparam logic [26:0] QN = 27'((64'd1 << 32) / 64'(ENTRIES));
    localparam logic [16:0] RN = 17'((64'd1 << 32) % 64'(ENTRIES));
    localparam logic [16:0] NK = 17'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_POLY = 3'b100
    } t_state;

    t_state             r_state;
    logic [4:0]         r_cnt;
    logic [2:0]         r_step;
    logic [IW-1:0]      r_idx;
    logic [31:0]        r_t;
    logic [16:0]        r_q;
    logic [17:0]        r_rem;
    logic [31:0]        r_quot;
    logic               r_cos;
    logic [1:0]         r_quad;
    logic [30:0]        r_z, r_z2, r_h;
    logic               r_done;
    logic signed [15:0] r_value;

    logic [15+NW:0] w_idx_prod;
    logic [57:0]    w_tq;
    logic [32:0]    w_qn, w_rm;
    logic [31:0]    w_t;
    logic [30:0]    w_ma, w_mb;
    logic [61:0]    w_prod;
    logic [32:0]    w_vr;

    // turn = idx * (2^32 div N) + (idx * (2^32 mod N)) div N, the last by reciprocal
    assign w_idx_prod = (16 + NW)'(i_phase) * (16 + NW)'(ENTRIES);
    assign w_tq       = 58'(r_t) * 58'(QN);
    assign w_qn       = 33'(r_q) * 33'(NK);
    assign w_rm       = {1'b0, r_t} - w_qn;
    assign w_t        = r_quot + {r_cos, 31'd0} / 2;
    assign w_prod     = 62'(w_ma) * 62'(w_mb);
    assign w_vr       = {1'b0, w_prod[61:30]} + 33'd32768;

    always_comb begin
        w_ma = r_z2;
        w_mb = r_h;
        case (r_step)
            3'd1:    begin w_ma = r_z;  w_mb = r_z;    end
            3'd2:    begin w_ma = r_z2; w_mb = POLY_C9; end
            3'd6:    begin w_ma = r_z;  w_mb = r_h;    end
            default: begin w_ma = r_z2; w_mb = r_h;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd3) begin
                        r_state <= S_POLY;
                        r_step  <= '0;
                    end
                end
                S_POLY: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd6) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_idx <= w_idx_prod[15+IW:16];
            r_cos <= i_cos;
        end
        if (r_state == S_DIV) begin
            case (r_cnt)
                5'd0: begin
                    r_t    <= 32'(r_idx) * 32'(RN);
                    r_quot <= 32'(r_idx) * 32'(QN);
                end
                5'd1: r_q   <= w_tq[48:32];
                5'd2: r_rem <= w_rm[17:0];
                default: r_quot <= r_quot + 32'(r_q) + 32'(r_rem >= 18'(NK));
            endcase
        end
        if (r_state == S_POLY) begin
            case (r_step)
                3'd0: begin
                    r_quad <= w_t[31:30];
                    r_z    <= w_t[30] ? 31'h4000_0000 - {1'b0, w_t[29:0]} : {1'b0, w_t[29:0]};
                end
                3'd1: r_z2 <= w_prod[60:30];
                3'd2: r_h  <= POLY_C7 - w_prod[60:30];
                3'd3: r_h  <= POLY_C5 - w_prod[60:30];
                3'd4: r_h  <= POLY_C3 - w_prod[60:30];
                3'd5: r_h  <= POLY_C1 - w_prod[60:30];
                default: begin
                    r_value <= r_quad[1] ? -$signed(w_vr[31:16]) : $signed(w_vr[31:16]);
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

FILE: hw/rtl/wep_lane.sv
// wep_lane: rotates and projects one endpoint to screen space
// depends on wep_pkg and wep_div

module wep_lane import wep_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    input  t_trig              i_trig,
    input  t_view              i_view,
    output t_point             o_res
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ROT  = 7'b0000010,
        S_ZC   = 7'b0000100,
        S_NUMX = 7'b0001000,
        S_NUMY = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [2:0]         r_step;
    logic signed [15:0] r_x, r_y, r_z;
    logic signed [37:0] r_acc;
    logic signed [19:0] r_y1, r_z1, r_x2, r_z2;
    logic [17:0]        r_zc;
    logic [34:0]        r_nx, r_ny;
    logic               r_negx, r_negy, r_div_go;
    logic signed [15:0] r_sx, r_sy;

    logic signed [19:0] w_ma;
    logic signed [15:0] w_mb;
    logic               w_sub;
    logic signed [35:0] w_prod;
    logic signed [37:0] w_sum, w_rnd;
    logic signed [20:0] w_zc;
    logic signed [19:0] w_nsrc;
    logic signed [36:0] w_nm, w_nabs;
    logic [34:0]        w_num;
    logic [34:0]        w_qx, w_qy;
    logic               w_done_x, w_done_y;
    logic signed [36:0] w_scr_x, w_scr_y;

    always_comb begin
        w_ma  = 20'(r_y);
        w_mb  = i_trig.csx;
        w_sub = 1'b0;
        case (r_step)
            3'd0: begin w_ma = 20'(r_y); w_mb = i_trig.csx; end
            3'd1: begin w_ma = 20'(r_z); w_mb = i_trig.snx; w_sub = 1'b1; end
            3'd2: begin w_ma = 20'(r_y); w_mb = i_trig.snx; end
            3'd3: begin w_ma = 20'(r_z); w_mb = i_trig.csx; end
            3'd4: begin w_ma = 20'(r_x); w_mb = i_trig.csy; end
            3'd5: begin w_ma = r_z1;     w_mb = i_trig.sny; end
            3'd6: begin w_ma = r_z1;     w_mb = i_trig.csy; end
            default: begin w_ma = 20'(r_x); w_mb = i_trig.sny; w_sub = 1'b1; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_sum  = w_sub ? r_acc - 38'(w_prod) : r_acc + 38'(w_prod);
    assign w_rnd  = w_sum + 38'sd8192;

    assign w_zc   = 21'(r_z2) + $signed({5'd0, i_view.view_distance});
    assign w_nsrc = (r_state == S_NUMX) ? r_x2 : r_y1;
    assign w_nm   = w_nsrc * $signed({1'b0, i_view.zoom});
    assign w_nabs = w_nm[36] ? -w_nm : w_nm;
    assign w_num  = w_nabs[34:0] + 35'({r_zc, 1'b0});

    wep_div #(.NW(35), .DW(20)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_nx),
        .i_den   ({r_zc, 2'b00}),
        .o_done  (w_done_x),
        .o_quot  (w_qx)
    );

    wep_div #(.NW(35), .DW(20)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_ny),
        .i_den   ({r_zc, 2'b00}),
        .o_done  (w_done_y),
        .o_quot  (w_qy)
    );

    assign w_scr_x = r_negx ? $signed({21'd0, i_view.center_x, 4'd0}) - $signed({2'b0, w_qx})
                            : $signed({21'd0, i_view.center_x, 4'd0}) + $signed({2'b0, w_qx});
    assign w_scr_y = r_negy ? $signed({21'd0, i_view.center_y, 4'd0}) - $signed({2'b0, w_qy})
                            : $signed({21'd0, i_view.center_y, 4'd0}) + $signed({2'b0, w_qy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            unique case (r_state)
                S_IDLE, S_DONE: begin
                    if (i_start) begin
                        r_state <= S_ROT;
                        r_step  <= '0;
                    end
                end
                S_ROT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd7) begin
                        r_state <= S_ZC;
                    end
                end
                S_ZC:   r_state <= S_NUMX;
                S_NUMX: r_state <= S_NUMY;
                S_NUMY: begin
                    r_state  <= S_DIV;
                    r_div_go <= 1'b1;
                end
                S_DIV: begin
                    if (w_done_x && w_done_y) begin
                        r_state <= S_DONE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE || r_state == S_DONE) && i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end
        if (r_state == S_ROT) begin
            case (r_step)
                3'd1:    r_y1  <= w_rnd[33:14];
                3'd3:    r_z1  <= w_rnd[33:14];
                3'd5:    r_x2  <= w_rnd[33:14];
                3'd7:    r_z2  <= w_rnd[33:14];
                default: r_acc <= 38'(w_prod);
            endcase
        end
        if (r_state == S_ZC) begin
            r_zc <= (w_zc < MIN_Z) ? 18'(MIN_Z) : w_zc[17:0];
        end
        if (r_state == S_NUMX) begin
            r_nx   <= w_num;
            r_negx <= w_nm[36];
        end
        if (r_state == S_NUMY) begin
            r_ny   <= w_num;
            r_negy <= w_nm[36];
        end
        if (r_state == S_DIV && w_done_x) begin
            r_sx <= sat16(w_scr_x);
            r_sy <= sat16(w_scr_y);
        end
    end

    assign o_res.valid = (r_state == S_DONE);
    assign o_res.sx    = r_sx;
    assign o_res.sy    = r_sy;

endmodule

FILE: hw/rtl/wep_merge.sv
// wep_merge: combines the two projected endpoints into six quad vertices, or none if they coincide
// depends on wep_pkg and wep_div

module wep_merge import wep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_point      i_a,
    input  t_point      i_b,
    output logic        o_ready,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,   // vertex_x, vertex_y
    output logic        o_tlast    // is_last
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQX  = 7'b0000010,
        S_SQY  = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_NUM  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state             r_state;
    logic signed [15:0] r_ax, r_ay, r_bx, r_by;
    logic signed [16:0] r_dx, r_dy;
    logic [41:0]        r_v, r_r, r_bit;
    logic [25:0]        r_nx, r_ny;
    logic [20:0]        r_len;
    logic               r_negx, r_negy, r_div_go;
    logic signed [22:0] r_ox, r_oy;
    logic [2:0]         r_k;
    logic               r_ovalid, r_olast;
    logic signed [15:0] r_vx, r_vy;

    logic signed [16:0] w_m;
    logic signed [33:0] w_sq;
    logic [41:0]        w_t;
    logic [16:0]        w_adx, w_ady;
    logic [25:0]        w_qx, w_qy;
    logic               w_done_x, w_done_y;
    logic               w_load, w_use_a, w_plus;
    logic signed [22:0] w_vx, w_vy;

    assign w_m   = (r_state == S_SQX) ? r_dx : r_dy;
    assign w_sq  = w_m * w_m;
    assign w_t   = r_r + r_bit;
    assign w_adx = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
    assign w_ady = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);

    wep_div #(.NW(26), .DW(21)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_nx),
        .i_den   (r_len),
        .o_done  (w_done_x),
        .o_quot  (w_qx)
    );

    wep_div #(.NW(26), .DW(21)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_ny),
        .i_den   (r_len),
        .o_done  (w_done_y),
        .o_quot  (w_qy)
    );

    // corner order a+ a- b- a+ b- b+
    assign w_use_a = (r_k == 3'd0) || (r_k == 3'd1) || (r_k == 3'd3);
    assign w_plus  = (r_k == 3'd0) || (r_k == 3'd3) || (r_k == 3'd5);
    assign w_vx    = w_plus ? 23'(w_use_a ? r_ax : r_bx) + r_ox
                            : 23'(w_use_a ? r_ax : r_bx) - r_ox;
    assign w_vy    = w_plus ? 23'(w_use_a ? r_ay : r_by) + r_oy
                            : 23'(w_use_a ? r_ay : r_by) - r_oy;
    assign w_load  = (r_state == S_EMIT) && (!r_ovalid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div_go <= 1'b0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            r_div_go <= 1'b0;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_state <= (r_dx == '0 && r_dy == '0) ? S_IDLE : S_SQY;
                end
                S_SQY: r_state <= S_SQRT;
                S_SQRT: begin
                    if (r_bit == 42'd1) begin
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_state  <= S_DIV;
                    r_div_go <= 1'b1;
                end
                S_DIV: begin
                    if (w_done_x && w_done_y) begin
                        r_state <= S_EMIT;
                        r_k     <= '0;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == 3'd5) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_ax <= i_a.sx;
            r_ay <= i_a.sy;
            r_bx <= i_b.sx;
            r_by <= i_b.sy;
            r_dx <= 17'(i_b.sx) - 17'(i_a.sx);
            r_dy <= 17'(i_b.sy) - 17'(i_a.sy);
        end
        if (r_state == S_SQX) begin
            r_v <= 42'(w_sq[33:0]);
        end
        if (r_state == S_SQY) begin
            r_v   <= {r_v[33:0] + w_sq[33:0], 8'd0};
            r_r   <= '0;
            r_bit <= 42'd1 << 40;
        end
        if (r_state == S_SQRT) begin
            if (r_v >= w_t) begin
                r_v <= r_v - w_t;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == S_NUM) begin
            r_len  <= r_r[20:0];
            r_nx   <= {1'b0, w_ady[15:0], 9'd0} + 26'(r_r[20:1]);
            r_ny   <= {1'b0, w_adx[15:0], 9'd0} + 26'(r_r[20:1]);
            r_negx <= ~r_dy[16];
            r_negy <= r_dx[16];
        end
        if (r_state == S_DIV && w_done_x) begin
            r_ox <= r_negx ? -$signed({1'b0, w_qx[21:0]}) : $signed({1'b0, w_qx[21:0]});
            r_oy <= r_negy ? -$signed({1'b0, w_qy[21:0]}) : $signed({1'b0, w_qy[21:0]});
        end
        if (w_load) begin
            r_vx    <= sat16(37'(w_vx));
            r_vy    <= sat16(37'(w_vy));
            r_olast <= (r_k == 3'd5);
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_tvalid = r_ovalid;
    assign o_tdata  = {r_vy, r_vx};
    assign o_tlast  = r_olast;

endmodule

FILE: hw/rtl/wireframe_edge_projector.sv
// Wireframe edge projector: a tick item advances the two rotation phases, an edge item is
// projected by two endpoint lanes side by side and merged into six quad vertices. After reset
// and after every tick the four sine and cosine values are rebuilt by one serial unit, during
// which no item is taken. An edge runs through the lanes (eight rotation products on one
// multiplier, then a 35 step divider), then through the merge stage (21 step square root, 26
// step divider, six vertices); a new item is taken while the merge stage still emits. A tick
// updates both phases in its own state and then rebuilds the trig values. Segments whose
// screen endpoints coincide give no vertex. Config writes are taken at once.
// depends on wep_pkg, wep_sine, wep_lane, wep_merge, wep_div

module wireframe_edge_projector import wep_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // time_step, a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [0:0]   s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // vertex_x, vertex_y
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_data
);
    typedef enum logic [3:0] {
        S_TRIG = 4'b0001,
        S_IDLE = 4'b0010,
        S_TICK = 4'b0100,
        S_LANE = 4'b1000
    } t_state;

    t_state             r_state;
    logic [16:0]        r_speed_x, r_speed_y;
    t_view              r_view;
    logic [15:0]        r_phase_x, r_phase_y;
    logic [15:0]        r_ts;
    logic signed [15:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    t_trig              r_trig;
    logic [1:0]         r_trig_idx;
    logic               r_sine_go, r_sine_wait, r_lane_go, r_merge_go;

    logic               w_accept;
    logic               w_sine_done;
    logic signed [15:0] w_sine;
    logic [32:0]        w_step_x, w_step_y;
    t_point             w_lane_a, w_lane_b;
    logic               w_merge_ready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_step_x      = 33'(r_ts) * 33'(r_speed_x);
    assign w_step_y      = 33'(r_ts) * 33'(r_speed_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_x          <= '0;
            r_speed_y          <= '0;
            r_view.view_distance <= 16'd12288;
            r_view.zoom        <= 16'd12800;
            r_view.center_x    <= 12'd400;
            r_view.center_y    <= 12'd300;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPEED_X:  r_speed_x            <= i_cfg_data;
                CFG_SPEED_Y:  r_speed_y            <= i_cfg_data;
                CFG_VIEW:     r_view.view_distance <= i_cfg_data[15:0];
                CFG_ZOOM:     r_view.zoom          <= i_cfg_data[15:0];
                CFG_CENTER_X: r_view.center_x      <= i_cfg_data[11:0];
                CFG_CENTER_Y: r_view.center_y      <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    wep_sine #(.ENTRIES(SINE_TABLE_ENTRIES)) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sine_go),
        .i_phase (r_trig_idx[1] ? r_phase_y : r_phase_x),
        .i_cos   (r_trig_idx[0]),
        .o_done  (w_sine_done),
        .o_value (w_sine)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_TRIG;
            r_phase_x   <= '0;
            r_phase_y   <= '0;
            r_trig_idx  <= '0;
            r_sine_go   <= 1'b0;
            r_sine_wait <= 1'b0;
            r_lane_go   <= 1'b0;
            r_merge_go  <= 1'b0;
        end else begin
            r_sine_go  <= 1'b0;
            r_lane_go  <= 1'b0;
            r_merge_go <= 1'b0;
            unique case (r_state)
                S_TRIG: begin
                    if (!r_sine_wait) begin
                        r_sine_go   <= 1'b1;
                        r_sine_wait <= 1'b1;
                    end else if (w_sine_done) begin
                        r_sine_wait <= 1'b0;
                        r_trig_idx  <= r_trig_idx + 1'b1;
                        if (r_trig_idx == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser[0] == ACT_EDGE) begin
                            r_state   <= S_LANE;
                            r_lane_go <= 1'b1;
                        end else begin
                            r_state <= S_TICK;
                        end
                    end
                end
                S_TICK: begin
                    r_phase_x <= r_phase_x + w_step_x[31:16];
                    r_phase_y <= r_phase_y + w_step_y[31:16];
                    r_state   <= S_TRIG;
                end
                S_LANE: begin
                    if (!r_lane_go && w_lane_a.valid && w_lane_b.valid && w_merge_ready) begin
                        r_merge_go <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ts <= s_axis_tdata[15:0];
            r_ax <= s_axis_tdata[31:16];
            r_ay <= s_axis_tdata[47:32];
            r_az <= s_axis_tdata[63:48];
            r_bx <= s_axis_tdata[79:64];
            r_by <= s_axis_tdata[95:80];
            r_bz <= s_axis_tdata[111:96];
        end
        if (r_state == S_TRIG && r_sine_wait && w_sine_done) begin
            case (r_trig_idx)
                2'd0:    r_trig.snx <= w_sine;
                2'd1:    r_trig.csx <= w_sine;
                2'd2:    r_trig.sny <= w_sine;
                default: r_trig.csy <= w_sine;
            endcase
        end
    end

    wep_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lane_go),
        .i_x     (r_ax),
        .i_y     (r_ay),
        .i_z     (r_az),
        .i_trig  (r_trig),
        .i_view  (r_view),
        .o_res   (w_lane_a)
    );

    wep_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lane_go),
        .i_x     (r_bx),
        .i_y     (r_by),
        .i_z     (r_bz),
        .i_trig  (r_trig),
        .i_view  (r_view),
        .o_res   (w_lane_b)
    );

    wep_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_merge_go),
        .i_a      (w_lane_a),
        .i_b      (w_lane_b),
        .o_ready  (w_merge_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_a.valid == w_lane_b.valid)
        else $error("endpoint lanes out of step");

    a_edge_starts_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser[0] == ACT_EDGE) |=> ##1 !w_lane_a.valid)
        else $error("edge item did not start the lanes");

    a_merge_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_merge_go |-> w_merge_ready)
        else $error("merge stage started while busy");
`endif

endmodule

FILE: verif/wireframe_edge_projector_checker.sv
// wireframe_edge_projector_checker: watches the item, vertex and register channels of the
// edge projector, predicts every vertex from its own copy of phases and registers and compares
// depends on wep_pkg for the register index names, action codes, polynomial constants and MIN_Z

module wireframe_edge_projector_checker import wep_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_tvalid,
    input  logic         i_in_tready,
    input  logic [111:0] i_in_tdata,
    input  logic [0:0]   i_in_tuser,
    input  logic         i_out_tvalid,
    input  logic         i_out_tready,
    input  logic [31:0]  i_out_tdata,
    input  logic         i_out_tlast,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               last;
    } t_vertex;

    t_vertex vertex_q[$];

    logic [16:0] speed_x, speed_y;
    logic [15:0] view_dist, zoom;
    logic [11:0] centre_x, centre_y;
    logic [15:0] phase_x, phase_y;

    function automatic longint sat_q12_4(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint div_away(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // sine of t / 2^32 turn in Q2.14, odd polynomial on the quarter wave
    function automatic longint sine_q14(longint unsigned t);
        longint unsigned quad, z, z2, h, s;
        longint v;
        t = t & 64'hFFFF_FFFF;
        quad = (t >> 30) & 3;
        z = quad[0] ? (64'd1 << 30) - (t & 64'h3FFF_FFFF) : (t & 64'h3FFF_FFFF);
        z2 = (z * z) >> 30;
        h = 64'(POLY_C7) - ((z2 * 64'(POLY_C9)) >> 30);
        h = 64'(POLY_C5) - ((z2 * h) >> 30);
        h = 64'(POLY_C3) - ((z2 * h) >> 30);
        h = 64'(POLY_C1) - ((z2 * h) >> 30);
        s = (z * h) >> 30;
        v = longint'((s + 32768) >> 16);
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic longint unsigned phase_turn(logic [15:0] ph);
        longint unsigned idx;
        idx = (longint'(ph) * SINE_TABLE_ENTRIES) >> 16;
        return (idx << 32) / SINE_TABLE_ENTRIES;
    endfunction

    function automatic longint q26_to_q12(longint v);
        return (v + 8192) >>> 14;
    endfunction

    task automatic project_point(input longint x, input longint y, input longint z,
                                 output longint sx, output longint sy);
        longint unsigned tx, ty;
        longint snx, csx, sny, csy, y1, z1, x2, z2, zc;
        tx = phase_turn(phase_x);
        ty = phase_turn(phase_y);
        snx = sine_q14(tx);
        csx = sine_q14(tx + (64'd1 << 30));
        sny = sine_q14(ty);
        csy = sine_q14(ty + (64'd1 << 30));
        y1 = q26_to_q12(y * csx - z * snx);
        z1 = q26_to_q12(y * snx + z * csx);
        x2 = q26_to_q12(x * csy + z1 * sny);
        z2 = q26_to_q12(z1 * csy - x * sny);
        zc = z2 + longint'(view_dist);
        if (zc < longint'(MIN_Z)) zc = longint'(MIN_Z);
        sx = sat_q12_4(longint'(centre_x) * 16 + div_away(x2 * longint'(zoom), zc * 4));
        sy = sat_q12_4(longint'(centre_y) * 16 + div_away(y1 * longint'(zoom), zc * 4));
    endtask

    task automatic push_vertex(input longint x, input longint y, input logic last);
        t_vertex v;
        v.vx = 16'(sat_q12_4(x));
        v.vy = 16'(sat_q12_4(y));
        v.last = last;
        vertex_q.push_back(v);
    endtask

    task automatic predict_item(input logic act, input logic [111:0] d);
        longint ax, ay, bx, by, dx, dy, len, ox, oy, ts;
        if (act == ACT_TICK) begin
            ts = longint'(d[15:0]);
            phase_x = 16'(longint'(phase_x) + ((ts * longint'(speed_x)) >> 16));
            phase_y = 16'(longint'(phase_y) + ((ts * longint'(speed_y)) >> 16));
        end else begin
            project_point(longint'($signed(d[31:16])), longint'($signed(d[47:32])),
                          longint'($signed(d[63:48])), ax, ay);
            project_point(longint'($signed(d[79:64])), longint'($signed(d[95:80])),
                          longint'($signed(d[111:96])), bx, by);
            dx = bx - ax;
            dy = by - ay;
            if (dx != 0 || dy != 0) begin
                len = root_floor(longint'((dx * dx + dy * dy) << 8));
                ox = div_away(-dy * 512, len);
                oy = div_away(dx * 512, len);
                push_vertex(ax + ox, ay + oy, 1'b0);
                push_vertex(ax - ox, ay - oy, 1'b0);
                push_vertex(bx - ox, by - oy, 1'b0);
                push_vertex(ax + ox, ay + oy, 1'b0);
                push_vertex(bx - ox, by - oy, 1'b0);
                push_vertex(bx + ox, by + oy, 1'b1);
            end
        end
    endtask

    task automatic report(input string what);
        o_fail_count++;
        if (o_fail_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_vertex e;
        if (!i_rst_n) begin
            vertex_q.delete();
            speed_x = '0;
            speed_y = '0;
            view_dist = 16'd12288;
            zoom = 16'd12800;
            centre_x = 12'd400;
            centre_y = 12'd300;
            phase_x = '0;
            phase_y = '0;
            o_fail_count = 0;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (vertex_q.size() == 0) begin
                    report($sformatf("unexpected vertex x=%0d y=%0d last=%0b",
                        $signed(i_out_tdata[15:0]), $signed(i_out_tdata[31:16]), i_out_tlast));
                end else begin
                    e = vertex_q.pop_front();
                    if (e.vx !== $signed(i_out_tdata[15:0]) ||
                        e.vy !== $signed(i_out_tdata[31:16]) || e.last !== i_out_tlast)
                        report($sformatf("expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                            e.vx, e.vy, e.last, $signed(i_out_tdata[15:0]),
                            $signed(i_out_tdata[31:16]), i_out_tlast));
                end
            end
            if (i_in_tvalid && i_in_tready) predict_item(i_in_tuser[0], i_in_tdata);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPEED_X:  speed_x = i_cfg_data;
                    CFG_SPEED_Y:  speed_y = i_cfg_data;
                    CFG_VIEW:     view_dist = i_cfg_data[15:0];
                    CFG_ZOOM:     zoom = i_cfg_data[15:0];
                    CFG_CENTER_X: centre_x = i_cfg_data[11:0];
                    CFG_CENTER_Y: centre_y = i_cfg_data[11:0];
                    default: ;
                endcase
            end
        end
        o_pending = vertex_q.size();
    end

endmodule

FILE: verif/wireframe_edge_projector_test.sv
// wireframe_edge_projector_test: drives ticks, edges and register writes into the edge
// projector under random idling and gives the verdict
// depends on wep_pkg, wireframe_edge_projector and wireframe_edge_projector_checker

module wireframe_edge_projector_test import wep_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_SPARE = 3'd6;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [111:0] s_data = '0;
    logic [0:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [31:0]  m_data;
    logic         m_last;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [16:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int tx_idle = 0;
    int rx_idle = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    wireframe_edge_projector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    wireframe_edge_projector_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_tvalid(s_valid), .i_in_tready(s_ready),
        .i_in_tdata(s_data), .i_in_tuser(s_user),
        .i_out_tvalid(m_valid), .i_out_tready(m_ready),
        .i_out_tdata(m_data), .i_out_tlast(m_last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [15:0] ts,
                             input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                             input logic [15:0] bx, input logic [15:0] by, input logic [15:0] bz);
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= act;
        s_data <= {bz, by, bx, az, ay, ax, ts};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_edge(input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                             input logic [15:0] bx, input logic [15:0] by, input logic [15:0] bz);
        send_item(ACT_EDGE, 16'($urandom), ax, ay, az, bx, by, bz);
    endtask

    task automatic send_tick(input logic [15:0] ts);
        send_item(ACT_TICK, ts, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // waits until the block has drained, then writes one register
    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        if ($urandom_range(99) < 85) return 16'($urandom_range(16384) - 8192);
        return 16'($urandom);
    endfunction

    function automatic logic [16:0] pick(input int hi);
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'(hi);
            default: return 17'($urandom_range(hi));
        endcase
    endfunction

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_edge(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_edge(16'd4096, 16'd0, 16'd0, -16'sd4096, 16'd0, 16'd0);
        send_edge(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_edge(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_tick(16'hFFFF);
        write_reg(CFG_SPEED_X, 17'd104308);
        write_reg(CFG_SPEED_Y, 17'd104308);
        write_reg(CFG_VIEW, 17'd0);
        write_reg(CFG_ZOOM, 17'd64000);
        write_reg(CFG_CENTER_X, 17'd4095);
        write_reg(CFG_CENTER_Y, 17'd4095);
        write_reg(CFG_SPARE, 17'h1FFFF);
        send_tick(16'hFFFF);
        send_tick(16'd1000);
        send_edge(16'd4096, 16'd4096, 16'd0, -16'sd4096, 16'd0, 16'd4096);
        send_edge(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        write_reg(CFG_ZOOM, 17'd0);
        write_reg(CFG_VIEW, 17'd40960);
        write_reg(CFG_CENTER_X, 17'd0);
        write_reg(CFG_CENTER_Y, 17'd0);
        write_reg(CFG_SPEED_X, 17'd0);
        send_edge(16'd4096, 16'd0, 16'd0, -16'sd4096, 16'd2048, 16'd0);
        send_tick(16'd0);
        write_reg(CFG_ZOOM, 17'd64000);
        send_edge(16'h8000, 16'h8000, 16'd0, 16'h8000, 16'h7FFF, 16'd0);
        send_edge(16'd100, 16'd200, 16'd300, 16'd101, 16'd200, 16'd300);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 26 : (ph == 1) ? 76 : 0;
            rx_idle = (ph == 0) ? 76 : (ph == 1) ? 26 : 0;
            write_reg(CFG_SPEED_X, pick(104308));
            write_reg(CFG_SPEED_Y, pick(104308));
            write_reg(CFG_VIEW, pick(40960));
            write_reg(CFG_ZOOM, 17'($urandom_range(64000)));
            write_reg(CFG_CENTER_X, pick(4095));
            write_reg(CFG_CENTER_Y, pick(4095));
            if (ph == 1) hold_req = 1;
            for (int n = 0; n < 80; n++) begin
                if ($urandom_range(99) < 20)
                    send_tick(16'($urandom));
                else
                    send_edge(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord());
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/wep_pkg.sv
hw/rtl/wep_div.sv
hw/rtl/wep_sine.sv
hw/rtl/wep_lane.sv
hw/rtl/wep_merge.sv
hw/rtl/wireframe_edge_projector.sv
verif/wireframe_edge_projector_checker.sv
verif/wireframe_edge_projector_test.sv
